// ===== sv/jhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jhsp_pkg: shared types and constants of the JPEG header segment parser
// Item and record structs, parse modes, record kinds and marker codes.
// ----------------------------------------------------------------------------
package jhsp_pkg;

    localparam int MAX_SCAN_COMPONENTS = 4;
    localparam int OUT_FIFO_DEPTH      = 4;

    localparam logic [7:0] MARKER_DQT = 8'hDB;
    localparam logic [7:0] MARKER_DHT = 8'hC4;
    localparam logic [7:0] MARKER_SOF = 8'hC0;
    localparam logic [7:0] MARKER_DRI = 8'hDD;
    localparam logic [7:0] MARKER_SOS = 8'hDA;
    localparam logic [7:0] MARKER_RST = 8'hD0;   // RST0..RST7 share bits [7:3]
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_00    = 8'h00;
    localparam int         QUANT_ENTRIES = 64;
    localparam int         HUFF_LENGTHS  = 16;

    typedef enum logic [3:0] {
        M_SEARCH     = 4'd0,
        M_LEN_HI     = 4'd1,
        M_LEN_LO     = 4'd2,
        M_DQT_HEAD   = 4'd3,
        M_DQT_BODY   = 4'd4,
        M_DHT_HEAD   = 4'd5,
        M_DHT_COUNTS = 4'd6,
        M_DHT_SYMS   = 4'd7,
        M_SOF_FIELDS = 4'd8,
        M_SOF_COMP   = 4'd9,
        M_DRI_BODY   = 4'd10,
        M_SOS_NS     = 4'd11,
        M_SOS_COMP   = 4'd12,
        M_SKIP       = 4'd13,
        M_SCAN       = 4'd14
    } t_mode;

    typedef enum logic [3:0] {
        K_QUANT_ENTRY = 4'd0,
        K_HUFF_COUNT  = 4'd1,
        K_HUFF_SYMBOL = 4'd2,
        K_FRAME_SIZE  = 4'd3,
        K_FRAME_COMP  = 4'd4,
        K_RESTART     = 4'd5,
        K_SCAN_COMP   = 4'd6,
        K_SCAN_BYTE   = 4'd7,
        K_SCAN_END    = 4'd8
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_image;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  slot;
        logic [3:0]  select_a;
        logic [3:0]  select_b;
        logic [15:0] value;
        logic [15:0] aux;
        logic [31:0] scan_length;
        logic [26:0] mcu_total;
        logic        last_of_item;
    } t_out_item;

    function automatic t_out_item mk_rec(t_kind kind, logic [7:0] slot, logic [3:0] sa,
                                         logic [3:0] sb, logic [15:0] value,
                                         logic [15:0] aux, logic [31:0] len,
                                         logic [26:0] mcu);
        t_out_item r;
        r.kind         = kind;
        r.slot         = slot;
        r.select_a     = sa;
        r.select_b     = sb;
        r.value        = value;
        r.aux          = aux;
        r.scan_length  = len;
        r.mcu_total    = mcu;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    function automatic logic is_parsed_marker(logic [7:0] b);
        return (b == MARKER_DQT) || (b == MARKER_DHT) || (b == MARKER_SOF) ||
               (b == MARKER_DRI) || (b == MARKER_SOS);
    endfunction

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

// ===== sv/jhsp_decode.sv =====
// ----------------------------------------------------------------------------
// jhsp_decode: byte-wise segment decoder
// Holds the parse state and turns one accepted byte into up to two records.
// ----------------------------------------------------------------------------
module jhsp_decode
    import jhsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    output t_out_item o_rec0,
    output t_out_item o_rec1,
    output logic [1:0] o_count
);

    t_mode        r_mode,  n_mode;
    logic         r_ff,    n_ff;
    logic [7:0]   r_st,    n_st;
    logic [15:0]  r_rem,   n_rem;
    logic [8:0]   r_fc,    n_fc;
    logic [3:0]   r_tn,    n_tn;
    logic         r_tc,    n_tc;
    logic [11:0]  r_sym,   n_sym;
    logic [7:0]   r_cc,    n_cc;
    logic [7:0]   r_ci,    n_ci;
    logic [15:0]  r_h,     n_h;
    logic [15:0]  r_w,     n_w;
    logic [15:0]  r_ri,    n_ri;
    logic [31:0]  r_sb,    n_sb;
    logic [7:0]   r_bh,    n_bh;
    logic [26:0]  r_mcu;

    logic [13:0]  mcu_w;
    logic [13:0]  mcu_h;
    logic [27:0]  mcu_prod;
    logic [15:0]  seg_len;
    logic [7:0]   b;
    logic         eob;
    t_out_item    rec, rec0, rec1;
    logic [1:0]   cnt;

    // Dimensions settle long before a scan can end, so registering the MCU product is safe.
    assign mcu_w    = 14'((17'(r_w) + 17'd7) >> 3);
    assign mcu_h    = 14'((17'(r_h) + 17'd7) >> 3);
    assign mcu_prod = mcu_w * mcu_h;

    assign b   = i_item.data_byte;
    assign eob = i_item.end_of_buffer;

    always_comb begin
        if (i_item.start_of_image) begin
            n_mode = M_SEARCH; n_ff = 1'b0; n_st = '0; n_rem = '0; n_fc = '0;
            n_tn = '0; n_tc = 1'b0; n_sym = '0; n_cc = '0; n_ci = '0;
            n_h = '0; n_w = '0; n_ri = '0; n_sb = '0; n_bh = '0;
        end else begin
            n_mode = r_mode; n_ff = r_ff; n_st = r_st; n_rem = r_rem; n_fc = r_fc;
            n_tn = r_tn; n_tc = r_tc; n_sym = r_sym; n_cc = r_cc; n_ci = r_ci;
            n_h = r_h; n_w = r_w; n_ri = r_ri; n_sb = r_sb; n_bh = r_bh;
        end
        rec     = '0;
        rec0    = '0;
        rec1    = '0;
        cnt     = 2'd0;
        seg_len = {n_bh, b};

        unique case (n_mode)
            M_SEARCH: begin
                if (n_ff) begin
                    if (b == BYTE_00) begin
                        n_ff = 1'b0;
                    end else if (b != BYTE_FF) begin
                        n_ff   = 1'b0;
                        n_st   = b;
                        n_mode = is_parsed_marker(b) ? M_LEN_HI : M_SEARCH;
                    end
                end else if (b == BYTE_FF) begin
                    n_ff = 1'b1;
                end
            end
            M_LEN_HI: begin
                n_bh   = b;
                n_mode = M_LEN_LO;
            end
            M_LEN_LO: begin
                n_rem = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                n_fc  = '0;
                n_ci  = '0;
                if (n_st == MARKER_DQT) begin
                    n_mode = M_DQT_HEAD;
                end else if (n_st == MARKER_DHT) begin
                    n_mode = M_DHT_HEAD;
                end else if (n_st == MARKER_SOF) begin
                    n_mode = M_SOF_FIELDS;
                end else if (n_st == MARKER_DRI) begin
                    n_mode = M_DRI_BODY;
                end else begin
                    n_mode = M_SOS_NS;
                    n_sb   = '0;
                    n_cc   = '0;
                end
                if (n_rem == 16'd0) begin
                    n_ff   = 1'b0;
                    n_mode = (n_st == MARKER_SOS) ? M_SCAN : M_SEARCH;
                end
            end
            M_SCAN: begin
                if (n_ff) begin
                    if (b == BYTE_00 || b[7:3] == MARKER_RST[7:3]) begin
                        // Stuffed byte or restart marker: pass both bytes, or only the 0xFF at end of buffer.
                        n_ff = 1'b0;
                        n_sb = sat_inc(n_sb);
                        rec0 = mk_rec(K_SCAN_BYTE, '0, '0, '0, {8'd0, BYTE_FF}, '0,
                                      n_sb, '0);
                        cnt  = 2'd1;
                        n_sb = sat_inc(n_sb);
                        if (!eob) begin
                            rec1 = mk_rec(K_SCAN_BYTE, '0, '0, '0, {8'd0, b}, '0,
                                          n_sb, '0);
                            cnt  = 2'd2;
                        end
                    end else begin
                        rec0   = mk_rec(K_SCAN_END, n_cc, '0, '0, '0, n_ri, n_sb, r_mcu);
                        cnt    = 2'd1;
                        n_mode = M_SEARCH;
                        if (b == BYTE_FF) begin
                            n_ff = 1'b1;
                        end else begin
                            n_ff   = 1'b0;
                            n_st   = b;
                            n_mode = is_parsed_marker(b) ? M_LEN_HI : M_SEARCH;
                        end
                    end
                end else if (b == BYTE_FF) begin
                    n_ff = 1'b1;
                end else begin
                    n_sb = sat_inc(n_sb);
                    rec0 = mk_rec(K_SCAN_BYTE, '0, '0, '0, {8'd0, b}, '0, n_sb, '0);
                    cnt  = 2'd1;
                end
            end
            default: begin
                // Segment body byte.
                n_rem = n_rem - 16'd1;
                case (n_mode)
                    M_DQT_HEAD: begin
                        n_tn   = b[3:0];
                        n_tc   = (b[7:4] != 4'd0);
                        n_fc   = '0;
                        n_mode = M_DQT_BODY;
                    end
                    M_DQT_BODY: begin
                        if (!n_tc) begin
                            rec0 = mk_rec(K_QUANT_ENTRY, n_fc[7:0], n_tn, '0, {8'd0, b},
                                          '0, '0, '0);
                            cnt  = 2'd1;
                            n_fc = n_fc + 9'd1;
                            if (n_fc >= 9'(QUANT_ENTRIES)) n_mode = M_DQT_HEAD;
                        end else begin
                            if (!n_fc[0]) begin
                                n_bh = b;
                            end else begin
                                rec0 = mk_rec(K_QUANT_ENTRY, n_fc[8:1], n_tn, '0,
                                              {n_bh, b}, '0, '0, '0);
                                cnt  = 2'd1;
                            end
                            n_fc = n_fc + 9'd1;
                            if (n_fc >= 9'(2 * QUANT_ENTRIES)) n_mode = M_DQT_HEAD;
                        end
                    end
                    M_DHT_HEAD: begin
                        n_tn   = b[3:0];
                        n_tc   = b[4];
                        n_fc   = '0;
                        n_sym  = '0;
                        n_mode = M_DHT_COUNTS;
                    end
                    M_DHT_COUNTS: begin
                        rec0  = mk_rec(K_HUFF_COUNT, n_fc[7:0], n_tn, {3'd0, n_tc},
                                       {8'd0, b}, '0, '0, '0);
                        cnt   = 2'd1;
                        n_sym = n_sym + 12'(b);
                        n_fc  = n_fc + 9'd1;
                        if (n_fc >= 9'(HUFF_LENGTHS)) begin
                            n_fc   = '0;
                            n_mode = (n_sym != 12'd0) ? M_DHT_SYMS : M_DHT_HEAD;
                        end
                    end
                    M_DHT_SYMS: begin
                        rec0  = mk_rec(K_HUFF_SYMBOL, n_fc[7:0], n_tn, {3'd0, n_tc},
                                       {8'd0, b}, '0, '0, '0);
                        cnt   = 2'd1;
                        n_fc  = n_fc + 9'd1;
                        n_sym = n_sym - 12'd1;
                        if (n_sym == 12'd0) n_mode = M_DHT_HEAD;
                    end
                    M_SOF_FIELDS: begin
                        if (n_fc == 9'd5) begin
                            n_cc   = b;
                            rec0   = mk_rec(K_FRAME_SIZE, b, '0, '0, n_h, n_w, '0, '0);
                            cnt    = 2'd1;
                            n_ci   = '0;
                            n_fc   = '0;
                            n_mode = (b != 8'd0) ? M_SOF_COMP : M_SKIP;
                        end else begin
                            if (n_fc == 9'd1) n_h = {b, 8'd0};
                            else if (n_fc == 9'd2) n_h = {n_h[15:8], b};
                            else if (n_fc == 9'd3) n_w = {b, 8'd0};
                            else if (n_fc == 9'd4) n_w = {n_w[15:8], b};
                            n_fc = n_fc + 9'd1;
                        end
                    end
                    M_SOF_COMP: begin
                        if (n_fc == 9'd0) begin
                            n_bh = b;
                            n_fc = 9'd1;
                        end else if (n_fc == 9'd1) begin
                            n_sym = {4'd0, b};
                            n_fc  = 9'd2;
                        end else begin
                            rec0 = mk_rec(K_FRAME_COMP, n_ci, n_sym[7:4], n_sym[3:0],
                                          {8'd0, n_bh}, {8'd0, b}, '0, '0);
                            cnt  = 2'd1;
                            n_ci = n_ci + 8'd1;
                            n_fc = '0;
                            if (n_ci >= n_cc) n_mode = M_SKIP;
                        end
                    end
                    M_DRI_BODY: begin
                        if (n_fc == 9'd0) begin
                            n_bh = b;
                            n_fc = 9'd1;
                        end else begin
                            n_ri   = {n_bh, b};
                            rec0   = mk_rec(K_RESTART, '0, '0, '0, n_ri, '0, '0, '0);
                            cnt    = 2'd1;
                            n_mode = M_SKIP;
                        end
                    end
                    M_SOS_NS: begin
                        n_cc   = (b > 8'(MAX_SCAN_COMPONENTS)) ? 8'(MAX_SCAN_COMPONENTS) : b;
                        n_ci   = '0;
                        n_fc   = '0;
                        n_mode = (n_cc != 8'd0) ? M_SOS_COMP : M_SKIP;
                    end
                    M_SOS_COMP: begin
                        if (n_fc == 9'd0) begin
                            n_bh = b;
                            n_fc = 9'd1;
                        end else begin
                            rec0 = mk_rec(K_SCAN_COMP, n_ci, b[7:4], b[3:0],
                                          {8'd0, n_bh}, '0, '0, '0);
                            cnt  = 2'd1;
                            n_ci = n_ci + 8'd1;
                            n_fc = '0;
                            if (n_ci >= n_cc) n_mode = M_SKIP;
                        end
                    end
                    default: begin
                    end
                endcase
                if (n_rem == 16'd0) begin
                    n_ff   = 1'b0;
                    n_mode = (n_st == MARKER_SOS) ? M_SCAN : M_SEARCH;
                end
            end
        endcase

        if (eob) begin
            if (n_mode == M_SCAN) begin
                rec = mk_rec(K_SCAN_END, n_cc, '0, '0, '0, n_ri, n_sb, r_mcu);
                if (cnt == 2'd0) rec0 = rec;
                else rec1 = rec;
                cnt = cnt + 2'd1;
            end
            n_mode = M_SEARCH;
            n_ff   = 1'b0;
        end

        if (cnt == 2'd1) rec0.last_of_item = 1'b1;
        if (cnt == 2'd2) rec1.last_of_item = 1'b1;
    end

    assign o_rec0  = rec0;
    assign o_rec1  = rec1;
    assign o_count = i_accept ? cnt : 2'd0;

    always_ff @(posedge i_clk) begin
        r_mcu <= 27'(mcu_prod);
        if (!i_rst_n) begin
            r_mode <= M_SEARCH; r_ff <= 1'b0; r_st <= '0; r_rem <= '0; r_fc <= '0;
            r_tn <= '0; r_tc <= 1'b0; r_sym <= '0; r_cc <= '0; r_ci <= '0;
            r_h <= '0; r_w <= '0; r_ri <= '0; r_sb <= '0; r_bh <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode; r_ff <= n_ff; r_st <= n_st; r_rem <= n_rem; r_fc <= n_fc;
            r_tn <= n_tn; r_tc <= n_tc; r_sym <= n_sym; r_cc <= n_cc; r_ci <= n_ci;
            r_h <= n_h; r_w <= n_w; r_ri <= n_ri; r_sb <= n_sb; r_bh <= n_bh;
        end
    end

endmodule

// ===== sv/jhsp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// jhsp_out_fifo: record queue
// Takes up to two records per cycle and hands out one per cycle while not stalled.
// ----------------------------------------------------------------------------
module jhsp_out_fifo
    import jhsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_out_item  i_rec0,
    input  t_out_item  i_rec1,
    input  logic [1:0] i_count,
    output logic       o_full,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_data
);

    localparam int PW = $clog2(OUT_FIFO_DEPTH);

    t_out_item     r_mem [OUT_FIFO_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_cnt, n_cnt;
    logic          pop;

    assign pop     = (r_cnt != '0) && !i_stall;
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    // Leave room for a full pair from the next byte.
    assign o_full  = (r_cnt > (PW+1)'(OUT_FIFO_DEPTH - 2));

    always_comb begin
        n_wr  = r_wr + PW'(i_count);
        n_rd  = r_rd + PW'(pop);
        n_cnt = r_cnt + (PW+1)'(i_count) - (PW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wr] <= i_rec0;
        if (i_count == 2'd2) r_mem[r_wr + PW'(1)] <= i_rec1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== sv/jpeg_header_segment_parser.sv =====
// ----------------------------------------------------------------------------
// jpeg_header_segment_parser: baseline JPEG marker and segment parser
// Decodes DQT, DHT, SOF0, DRI and SOS segments into records and passes scans.
// ----------------------------------------------------------------------------
// The parser takes one byte of a compressed image per cycle unless stalled
// and updates its parse state in that same cycle; every accepted byte is
// fully handled by the decoder logic between the state registers and a
// four-entry record queue. A byte yields zero, one or two records, queued
// together; the queue drains one record per cycle while the consumer does not
// stall, so input accepts one byte every cycle as long as the bytes average at
// most one record each (header tables and plain scan data); the stuffed-byte
// and restart pairs give two records each. Input stall rises when fewer than
// two queue entries are free. Records appear on the output at the earliest in
// the cycle after their byte is taken. The MCU product for the scan-end record
// is registered from the frame dimensions, always settled well ahead of a scan.
// ----------------------------------------------------------------------------
module jpeg_header_segment_parser
    import jhsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_out_item  rec0;
    t_out_item  rec1;
    logic [1:0] rec_count;
    logic       fifo_full;
    logic       in_accept;

    // Accept a byte whenever the queue can take a full record pair.
    assign o_in_stall = fifo_full;
    assign in_accept  = i_in_valid && !fifo_full;

    // Decode the byte and advance the parse state.
    jhsp_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_rec0   (rec0),
        .o_rec1   (rec1),
        .o_count  (rec_count)
    );

    // Hold records until the consumer takes them.
    jhsp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec0  (rec0),
        .i_rec1  (rec1),
        .i_count (rec_count),
        .o_full  (fifo_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

endmodule

// ===== sv/jhsp_checker.sv =====
// ----------------------------------------------------------------------------
// jhsp_checker: port-level checks of the parser
// Output handshake and record consistency as seen on the top-level ports.
// ----------------------------------------------------------------------------
module jhsp_checker
    import jhsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled output word changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word right after reset");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == K_SCAN_END |-> o_out_data.last_of_item)
        else $error("scan end not last of its byte");

    a_len_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != K_SCAN_BYTE && o_out_data.kind != K_SCAN_END
        |-> o_out_data.scan_length == 32'd0)
        else $error("scan length on a header record");

endmodule

bind jpeg_header_segment_parser jhsp_checker u_jhsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the JPEG header segment parser
// Feeds directed and random byte streams (well-formed images with tables,
// frames, restart intervals and scans, plus noise), predicts every record and
// compares records field by field as they leave the block.
// ----------------------------------------------------------------------------
module tb_top;
    import jhsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    jpeg_header_segment_parser uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor
    t_mode       pm;
    logic        p_ff;
    logic [7:0]  p_seg;
    logic [15:0] p_rem;
    logic [8:0]  p_fc;
    logic [3:0]  p_tn;
    logic        p_tc;
    logic [11:0] p_sym;
    logic [7:0]  p_cc, p_ci;
    logic [15:0] p_h, p_w, p_ri;
    logic [31:0] p_sb;
    logic [7:0]  p_hold;

    t_out_item   record_queue[$];   // records still owed by the block
    t_out_item   step_recs[$];      // records of the byte being predicted
    int          errors = 0;

    function automatic t_out_item rec(t_kind k, logic [7:0] s, logic [3:0] a, logic [3:0] b,
                                      logic [15:0] v, logic [15:0] x, logic [31:0] l,
                                      logic [26:0] m);
        t_out_item r;
        r.kind = k; r.slot = s; r.select_a = a; r.select_b = b; r.value = v;
        r.aux = x; r.scan_length = l; r.mcu_total = m; r.last_of_item = 1'b0;
        return r;
    endfunction

    task automatic parser_clear();
        pm = M_SEARCH; p_ff = 0; p_seg = 0; p_rem = 0; p_fc = 0; p_tn = 0; p_tc = 0;
        p_sym = 0; p_cc = 0; p_ci = 0; p_h = 0; p_w = 0; p_ri = 0; p_sb = 0; p_hold = 0;
    endtask

    task automatic push_rec(t_out_item r);
        if (step_recs.size() < 2) step_recs.push_back(r);
    endtask

    task automatic push_scan_end();
        logic [26:0] mcu;
        mcu = 27'(((32'(p_w) + 7) >> 3) * ((32'(p_h) + 7) >> 3));
        push_rec(rec(K_SCAN_END, p_cc, 0, 0, 0, p_ri, p_sb, mcu));
    endtask

    function automatic logic is_marker(logic [7:0] b);
        return b == MARKER_DQT || b == MARKER_DHT || b == MARKER_SOF ||
               b == MARKER_DRI || b == MARKER_SOS;
    endfunction

    task automatic open_marker(logic [7:0] b);
        p_ff = 0;
        p_seg = b;
        pm = is_marker(b) ? M_LEN_HI : M_SEARCH;
    endtask

    task automatic close_segment();
        p_ff = 0;
        pm = (p_seg == MARKER_SOS) ? M_SCAN : M_SEARCH;
    endtask

    task automatic bump_scan();
        if (p_sb != 32'hFFFF_FFFF) p_sb++;
    endtask

    task automatic decode_body(logic [7:0] b);
        p_rem = p_rem - 16'd1;
        case (pm)
            M_DQT_HEAD: begin
                p_tn = b[3:0]; p_tc = (b[7:4] != 0); p_fc = 0; pm = M_DQT_BODY;
            end
            M_DQT_BODY: begin
                if (!p_tc) begin
                    push_rec(rec(K_QUANT_ENTRY, p_fc[7:0], p_tn, 0, {8'h0, b}, 0, 0, 0));
                    p_fc++;
                    if (p_fc >= QUANT_ENTRIES) pm = M_DQT_HEAD;
                end else begin
                    if (!p_fc[0]) p_hold = b;
                    else push_rec(rec(K_QUANT_ENTRY, 8'(p_fc >> 1), p_tn, 0, {p_hold, b},
                                      0, 0, 0));
                    p_fc++;
                    if (p_fc >= 2 * QUANT_ENTRIES) pm = M_DQT_HEAD;
                end
            end
            M_DHT_HEAD: begin
                p_tn = b[3:0]; p_tc = b[4]; p_fc = 0; p_sym = 0; pm = M_DHT_COUNTS;
            end
            M_DHT_COUNTS: begin
                push_rec(rec(K_HUFF_COUNT, p_fc[7:0], p_tn, {3'b0, p_tc}, {8'h0, b}, 0, 0, 0));
                p_sym = p_sym + 12'(b);
                p_fc++;
                if (p_fc >= HUFF_LENGTHS) begin
                    p_fc = 0;
                    pm = (p_sym != 0) ? M_DHT_SYMS : M_DHT_HEAD;
                end
            end
            M_DHT_SYMS: begin
                push_rec(rec(K_HUFF_SYMBOL, p_fc[7:0], p_tn, {3'b0, p_tc}, {8'h0, b}, 0, 0, 0));
                p_fc++;
                p_sym--;
                if (p_sym == 0) pm = M_DHT_HEAD;
            end
            M_SOF_FIELDS: begin
                case (p_fc)
                    1: p_h = {b, 8'h0};
                    2: p_h[7:0] = b;
                    3: p_w = {b, 8'h0};
                    4: p_w[7:0] = b;
                    default: ;
                endcase
                if (p_fc == 5) begin
                    p_cc = b;
                    push_rec(rec(K_FRAME_SIZE, b, 0, 0, p_h, p_w, 0, 0));
                    p_ci = 0; p_fc = 0;
                    pm = (b != 0) ? M_SOF_COMP : M_SKIP;
                end else p_fc++;
            end
            M_SOF_COMP: begin
                if (p_fc == 0) begin
                    p_hold = b; p_fc = 1;
                end else if (p_fc == 1) begin
                    p_sym = 12'(b); p_fc = 2;
                end else begin
                    push_rec(rec(K_FRAME_COMP, p_ci, p_sym[7:4], p_sym[3:0], {8'h0, p_hold},
                                 {8'h0, b}, 0, 0));
                    p_ci++; p_fc = 0;
                    if (p_ci >= p_cc) pm = M_SKIP;
                end
            end
            M_DRI_BODY: begin
                if (p_fc == 0) begin
                    p_hold = b; p_fc = 1;
                end else begin
                    p_ri = {p_hold, b};
                    push_rec(rec(K_RESTART, 0, 0, 0, p_ri, 0, 0, 0));
                    pm = M_SKIP;
                end
            end
            M_SOS_NS: begin
                p_cc = (b > MAX_SCAN_COMPONENTS) ? 8'(MAX_SCAN_COMPONENTS) : b;
                p_ci = 0; p_fc = 0;
                pm = (p_cc != 0) ? M_SOS_COMP : M_SKIP;
            end
            M_SOS_COMP: begin
                if (p_fc == 0) begin
                    p_hold = b; p_fc = 1;
                end else begin
                    push_rec(rec(K_SCAN_COMP, p_ci, b[7:4], b[3:0], {8'h0, p_hold}, 0, 0, 0));
                    p_ci++; p_fc = 0;
                    if (p_ci >= p_cc) pm = M_SKIP;
                end
            end
            default: ;
        endcase
        if (p_rem == 0) close_segment();
    endtask

    task automatic decode_scan(logic [7:0] b, logic eob);
        if (p_ff) begin
            if (b == BYTE_00 || b[7:3] == MARKER_RST[7:3]) begin
                p_ff = 0;
                bump_scan();
                push_rec(rec(K_SCAN_BYTE, 0, 0, 0, {8'h0, BYTE_FF}, 0, p_sb, 0));
                bump_scan();
                if (!eob) push_rec(rec(K_SCAN_BYTE, 0, 0, 0, {8'h0, b}, 0, p_sb, 0));
            end else begin
                push_scan_end();
                pm = M_SEARCH;
                if (b == BYTE_FF) p_ff = 1;
                else open_marker(b);
            end
        end else if (b == BYTE_FF) begin
            p_ff = 1;
        end else begin
            bump_scan();
            push_rec(rec(K_SCAN_BYTE, 0, 0, 0, {8'h0, b}, 0, p_sb, 0));
        end
    endtask

    // Advance the predictor by one word and queue the records it causes.
    task automatic predict_word(t_in_item it);
        logic [7:0] b;
        logic [15:0] len;
        b = it.data_byte;
        step_recs.delete();
        if (it.start_of_image) parser_clear();
        case (pm)
            M_SEARCH: begin
                if (p_ff) begin
                    if (b == BYTE_00) p_ff = 0;
                    else if (b != BYTE_FF) open_marker(b);
                end else if (b == BYTE_FF) p_ff = 1;
            end
            M_LEN_HI: begin
                p_hold = b; pm = M_LEN_LO;
            end
            M_LEN_LO: begin
                len = {p_hold, b};
                p_rem = (len >= 2) ? len - 16'd2 : 16'd0;
                p_fc = 0; p_ci = 0;
                if (p_seg == MARKER_DQT) pm = M_DQT_HEAD;
                else if (p_seg == MARKER_DHT) pm = M_DHT_HEAD;
                else if (p_seg == MARKER_SOF) pm = M_SOF_FIELDS;
                else if (p_seg == MARKER_DRI) pm = M_DRI_BODY;
                else begin
                    pm = M_SOS_NS; p_sb = 0; p_cc = 0;
                end
                if (p_rem == 0) close_segment();
            end
            M_SCAN: decode_scan(b, it.end_of_buffer);
            default: decode_body(b);
        endcase
        if (it.end_of_buffer) begin
            if (pm == M_SCAN) push_scan_end();
            pm = M_SEARCH; p_ff = 0;
        end
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last_of_item = 1'b1;
        foreach (step_recs[i]) record_queue.push_back(step_recs[i]);
    endtask

    // ---------------------------------------------------------------- stimulus
    int sender_idle = 0;    // percent of cycles the sender holds off
    int receiver_idle = 0;  // percent of cycles the receiver stalls
    int hold_off = 0;       // cycles of forced receiver stall still to run
    int typed_rows = 0;
    t_out_item typed_queue[$];  // hand-written expectations, checked too
    t_in_item  word_queue[$];

    // Receiver: stall at random, or hold off for a long stretch on request.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle);
        end
    end

    // Record checker: compare each accepted record with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (record_queue.size() == 0) begin
                $error("record with nothing expected: kind %0d", o_out_data.kind);
                errors++;
            end else begin
                e = record_queue.pop_front();
                if (typed_queue.size() > 0 && typed_queue[0].kind == e.kind &&
                    typed_queue[0].value == e.value) begin
                    if (typed_queue[0] !== e) begin
                        $error("typed row disagrees with predictor");
                        errors++;
                    end
                    void'(typed_queue.pop_front());
                end
                if (o_out_data.kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_out_data.kind); errors++;
                end
                if (o_out_data.slot !== e.slot) begin
                    $error("slot: expected %0d, got %0d", e.slot, o_out_data.slot); errors++;
                end
                if (o_out_data.select_a !== e.select_a) begin
                    $error("select_a: expected %0d, got %0d", e.select_a,
                           o_out_data.select_a); errors++;
                end
                if (o_out_data.select_b !== e.select_b) begin
                    $error("select_b: expected %0d, got %0d", e.select_b,
                           o_out_data.select_b); errors++;
                end
                if (o_out_data.value !== e.value) begin
                    $error("value: expected %0h, got %0h", e.value, o_out_data.value); errors++;
                end
                if (o_out_data.aux !== e.aux) begin
                    $error("aux: expected %0h, got %0h", e.aux, o_out_data.aux); errors++;
                end
                if (o_out_data.scan_length !== e.scan_length) begin
                    $error("scan_length: expected %0d, got %0d", e.scan_length,
                           o_out_data.scan_length); errors++;
                end
                if (o_out_data.mcu_total !== e.mcu_total) begin
                    $error("mcu_total: expected %0d, got %0d", e.mcu_total,
                           o_out_data.mcu_total); errors++;
                end
                if (o_out_data.last_of_item !== e.last_of_item) begin
                    $error("last_of_item: expected %0b, got %0b", e.last_of_item,
                           o_out_data.last_of_item); errors++;
                end
            end
        end
    end

    function automatic t_in_item word(logic [7:0] b, logic soi = 0, logic eob = 0);
        t_in_item w;
        w.data_byte = b; w.start_of_image = soi; w.end_of_buffer = eob;
        return w;
    endfunction

    // Send one word: hold valid and payload until the block takes it.
    task automatic send_word(t_in_item w);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        predict_word(w);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic flush_words();
        while (word_queue.size() > 0) send_word(word_queue.pop_front());
    endtask

    task automatic add(logic [7:0] b);
        word_queue.push_back(word(b));
    endtask

    task automatic add_len(int n);
        add(8'(n >> 8)); add(8'(n));
    endtask

    // Build one image with random content, at times with one byte overwritten; mostly small segments.
    task automatic build_image();
        int n, cnt, tot;
        word_queue.push_back(word(BYTE_FF, 1'b1));
        add(8'hD8);
        repeat ($urandom_range(3)) begin
            case ($urandom_range(4))
                0: begin
                    n = $urandom_range(1);
                    add(BYTE_FF); add(MARKER_DQT);
                    add_len(n ? 131 : 67);
                    add({n ? 4'($urandom_range(1, 15)) : 4'h0, 4'($urandom)});
                    repeat (n ? 128 : 64) add(8'($urandom));
                end
                1: begin
                    add(BYTE_FF); add(MARKER_DHT);
                    tot = 0;
                    cnt = $urandom_range(12);
                    add_len(19 + cnt);
                    add({3'($urandom), 1'($urandom), 4'($urandom)});
                    for (int i = 0; i < 16; i++) begin
                        n = (i == 15) ? cnt - tot : $urandom_range(cnt - tot);
                        if ($urandom_range(3) != 0 && i != 15) n = 0;
                        add(8'(n)); tot += n;
                    end
                    repeat (cnt) add(8'($urandom));
                end
                2: begin
                    n = $urandom_range(1, 4);
                    add(BYTE_FF); add(MARKER_SOF);
                    add_len(8 + 3 * n);
                    repeat (5) add(8'($urandom));
                    add(8'(n));
                    repeat (3 * n) add(8'($urandom));
                end
                3: begin
                    add(BYTE_FF); add(MARKER_DRI); add_len(4);
                    add(8'($urandom)); add(8'($urandom));
                end
                default: begin
                    add(BYTE_FF); add(8'($urandom_range(8'hE0, 8'hEF)));
                    add(8'($urandom));
                end
            endcase
        end
        n = $urandom_range(1, 6);
        add(BYTE_FF); add(MARKER_SOS);
        add_len(6 + 2 * n);
        add(8'(n));
        repeat (2 * n) add(8'($urandom));
        repeat (3) add(8'($urandom));
        repeat ($urandom_range(40)) begin
            case ($urandom_range(9))
                0: begin add(BYTE_FF); add(BYTE_00); end
                1: begin add(BYTE_FF); add(8'($urandom_range(8'hD0, 8'hD7))); end
                2: add(BYTE_FF);
                default: add(8'($urandom));
            endcase
        end
        if ($urandom_range(1)) begin
            add(BYTE_FF); add(8'hD9);
        end
        if ($urandom_range(3) == 0) word_queue[$urandom_range(word_queue.size() - 1)] =
            word(8'($urandom));
        word_queue[word_queue.size() - 1].end_of_buffer = 1'b1;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (record_queue.size() > 0 && guard < 100000) begin
            @(posedge i_clk); guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Directed rows: byte, soi, eob.
    typedef struct {
        logic [7:0] b;
        logic       soi;
        logic       eob;
    } t_row;

    t_row rows[] = '{
        '{8'hFF, 1, 0}, '{8'hD8, 0, 0},                    // SOI marker, skipped
        '{8'hFF, 0, 0}, '{8'h00, 0, 0}, '{8'hFF, 0, 0}, '{8'hFF, 0, 0},
        '{8'hDD, 0, 0}, '{8'h00, 0, 0}, '{8'h04, 0, 0},    // DRI length 4
        '{8'hFF, 0, 0}, '{8'hFF, 0, 0},                    // restart 0xFFFF
        '{8'hFF, 0, 0}, '{8'hC4, 0, 0}, '{8'h00, 0, 0}, '{8'h01, 0, 0}, // short length
        '{8'hFF, 0, 0}, '{8'hDA, 0, 0}, '{8'h00, 0, 0}, '{8'h03, 0, 0},
        '{8'h00, 0, 0},                                    // no components
        '{8'h12, 0, 0}, '{8'hFF, 0, 0}, '{8'h00, 0, 0}, '{8'hFF, 0, 0},
        '{8'hD7, 0, 0}, '{8'hFF, 0, 1}                     // lone 0xFF at end
    };

    initial begin
        parser_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: the restart record and the scan end of the rows are typed in.
        typed_queue.push_back(rec(K_RESTART, 0, 0, 0, 16'hFFFF, 0, 0, 0));
        typed_queue.push_back(rec(K_SCAN_END, 0, 0, 0, 0, 16'hFFFF, 5, 0));
        typed_queue[1].last_of_item = 1'b1;
        typed_queue[0].last_of_item = 1'b1;
        foreach (rows[i]) send_word(word(rows[i].b, rows[i].soi, rows[i].eob));
        // Scan entered on the last byte, then a pair split by end of buffer.
        send_word(word(BYTE_FF, 1)); send_word(word(MARKER_SOS));
        send_word(word(8'h00)); send_word(word(8'h02, 0, 1));
        send_word(word(BYTE_FF, 1)); send_word(word(MARKER_SOS));
        send_word(word(8'h00)); send_word(word(8'h02));
        send_word(word(BYTE_FF)); send_word(word(BYTE_00, 0, 1));
        i_in_valid <= 1'b0;
        drain();
        if (typed_queue.size() > 0) begin
            $error("typed rows left unmatched: %0d", typed_queue.size());
            errors++;
        end

        // Random part in idling phases; one long receiver hold-off.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 59 : 26) : 0;
            receiver_idle = (ph == 2) ? 59 : (ph == 3 ? 26 : 0);
            if (ph == 0) hold_off = 300;
            typed_rows = 0;
            while (typed_rows < 340) begin
                build_image();
                typed_rows += word_queue.size();
                flush_words();
                if ($urandom_range(2) == 0) begin
                    repeat (8) send_word(word(8'($urandom), 1'($urandom), 1'($urandom)));
                    typed_rows += 8;
                end
            end
        end
        i_in_valid <= 1'b0;
        sender_idle = 0;
        receiver_idle = 0;
        drain();
        if (record_queue.size() == 0 && errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== jpeg_header_segment_parser.f =====
sv/jhsp_pkg.sv
sv/jhsp_decode.sv
sv/jhsp_out_fifo.sv
sv/jpeg_header_segment_parser.sv
sv/jhsp_checker.sv
tb/tb_top.sv
